FILE: sv/irn_pkg.sv
// ----------------------------------------------------------------------------
// irn_pkg
// Shared types, codes and helper functions for the nearest-neighbour
// rotation core.
// ----------------------------------------------------------------------------
package irn_pkg;

  localparam int DEF_MAX_WIDTH      = 256;
  localparam int DEF_MAX_HEIGHT     = 256;
  localparam int DEF_COEF_FRAC_BITS = 14;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;
  localparam int DIM_W       = 9;
  localparam int COEF_W      = 16;
  localparam int PIX_W       = 24;

  localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_COS_COEF     = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_SIN_COEF     = 2'd3;

  localparam logic [DIM_W-1:0]         IMAGE_WIDTH_RESET  = 9'd256;
  localparam logic [DIM_W-1:0]         IMAGE_HEIGHT_RESET = 9'd256;
  localparam logic signed [COEF_W-1:0] COS_RESET          = 16'sd15826;
  localparam logic signed [COEF_W-1:0] SIN_RESET          = 16'sd4240;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_FETCH = 1'b1;

  typedef struct packed {
    logic load_we;
    logic fetch_go;
    logic sum_en;
    logic rnd_en;
    logic rd_en;
  } irn_cmd_t;

  // Remainder of an 8-bit value by a constant, by shifted compare and subtract.
  function automatic logic [7:0] mod8(input logic [7:0] v, input int unsigned m);
    logic [31:0] r;
    r = 32'(v);
    for (int k = 7; k >= 0; k--) begin
      if (r >= (32'(m) << k)) begin
        r = r - (32'(m) << k);
      end
    end
    return r[7:0];
  endfunction

  // Saturate a dimension register to 1..maxv.
  function automatic logic [31:0] sat_dim(input logic [DIM_W-1:0] v, input int unsigned maxv);
    logic [31:0] r;
    r = 32'(v);
    if (r < 32'd1) begin
      r = 32'd1;
    end else if (r > 32'(maxv)) begin
      r = 32'(maxv);
    end
    return r;
  endfunction

endpackage

FILE: sv/image_rotate_nearest_core.sv
// ----------------------------------------------------------------------------
// image_rotate_nearest_core
// Nearest-neighbour image rotation over a three-channel frame store.
//
//   channel   handshake            word
//   -------   ------------------   -------------------------------------------
//   command   start / busy         op, col, row, chan0, chan1, chan2
//   result    done (strobe)        out_chan0..2, src_col, src_row, clamped
//   config    cfg_valid/cfg_ready  cfg_index, cfg_data
//
// A load word writes the store at the accepting edge. A fetch word steps
// through accept, sum, round and clamp, store read and result; the rotation
// products and the single store port call for these steps.
// done is high for exactly one cycle per fetch; the receiver cannot stall.
// Reset is synchronous; the frame store is not cleared and holds unknown
// data until written. cfg_ready is always high.
// ----------------------------------------------------------------------------
module image_rotate_nearest_core #(
  parameter int MAX_WIDTH      = irn_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT     = irn_pkg::DEF_MAX_HEIGHT,
  parameter int COEF_FRAC_BITS = irn_pkg::DEF_COEF_FRAC_BITS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic                            op,
  input  logic [7:0]                      col,
  input  logic [7:0]                      row,
  input  logic [7:0]                      chan0,
  input  logic [7:0]                      chan1,
  input  logic [7:0]                      chan2,
  output logic                            done,
  output logic [7:0]                      out_chan0,
  output logic [7:0]                      out_chan1,
  output logic [7:0]                      out_chan2,
  output logic [7:0]                      src_col,
  output logic [7:0]                      src_row,
  output logic                            clamped,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [irn_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [irn_pkg::CFG_DATA_W-1:0]  cfg_data
);

  import irn_pkg::*;

  irn_cmd_t cmd;
  logic     cfg_we;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid & cfg_ready;

  irn_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .op   (op),
    .busy (busy),
    .done (done),
    .cmd  (cmd)
  );

  irn_dpath #(
    .MAX_WIDTH     (MAX_WIDTH),
    .MAX_HEIGHT    (MAX_HEIGHT),
    .COEF_FRAC_BITS(COEF_FRAC_BITS)
  ) u_dpath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .col      (col),
    .row      (row),
    .chan0    (chan0),
    .chan1    (chan1),
    .chan2    (chan2),
    .out_chan0(out_chan0),
    .out_chan1(out_chan1),
    .out_chan2(out_chan2),
    .src_col  (src_col),
    .src_row  (src_row),
    .clamped  (clamped)
  );

endmodule

FILE: sv/irn_ram.sv
// ----------------------------------------------------------------------------
// irn_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module irn_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

FILE: sv/irn_ctrl.sv
// ----------------------------------------------------------------------------
// irn_ctrl
// Sequencer: accepts words, steps a fetch through multiply, sum, round and
// read, and strobes the result.
// ----------------------------------------------------------------------------
module irn_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              op,
  output logic              busy,
  output logic              done,
  output irn_pkg::irn_cmd_t cmd
);

  import irn_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SUM  = 3'd1;
  localparam logic [2:0] S_RND  = 3'd2;
  localparam logic [2:0] S_READ = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       accept;

  assign busy   = (state != S_IDLE);
  assign accept = start & ~busy;
  assign done   = (state == S_DONE);

  assign cmd.load_we  = accept & (op == OP_LOAD);
  assign cmd.fetch_go = accept & (op == OP_FETCH);
  assign cmd.sum_en   = (state == S_SUM);
  assign cmd.rnd_en   = (state == S_RND);
  assign cmd.rd_en    = (state == S_READ);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (cmd.fetch_go) begin
          state_next = S_SUM;
        end
      end
      S_SUM:  state_next = S_RND;
      S_RND:  state_next = S_READ;
      S_READ: state_next = S_DONE;
      S_DONE: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

FILE: sv/irn_dpath.sv
// ----------------------------------------------------------------------------
// irn_dpath
// Datapath: configuration registers, rotation products, rounding, edge
// clamping and the frame store.
// ----------------------------------------------------------------------------
module irn_dpath #(
  parameter int MAX_WIDTH      = irn_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT     = irn_pkg::DEF_MAX_HEIGHT,
  parameter int COEF_FRAC_BITS = irn_pkg::DEF_COEF_FRAC_BITS
) (
  input  logic                               clk,
  input  logic                               rst,
  input  irn_pkg::irn_cmd_t                  cmd,
  input  logic                               cfg_we,
  input  logic [irn_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [irn_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic [7:0]                         col,
  input  logic [7:0]                         row,
  input  logic [7:0]                         chan0,
  input  logic [7:0]                         chan1,
  input  logic [7:0]                         chan2,
  output logic [7:0]                         out_chan0,
  output logic [7:0]                         out_chan1,
  output logic [7:0]                         out_chan2,
  output logic [7:0]                         src_col,
  output logic [7:0]                         src_row,
  output logic                               clamped
);

  import irn_pkg::*;

  localparam int CB      = $clog2(MAX_WIDTH);
  localparam int RB      = $clog2(MAX_HEIGHT);
  localparam int ADDR_W  = CB + RB;
  localparam int DEPTH   = 2 ** ADDR_W;
  localparam int DW      = $clog2(MAX_WIDTH + 1);
  localparam int HW      = $clog2(MAX_HEIGHT + 1);
  localparam int PROD_W  = COEF_W + 9;
  localparam int ACC_W   = 28;
  localparam int XW      = ACC_W - COEF_FRAC_BITS;
  localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1 << (COEF_FRAC_BITS - 1));

  logic [DIM_W-1:0]         image_width;
  logic [DIM_W-1:0]         image_height;
  logic signed [COEF_W-1:0] cos_coef;
  logic signed [COEF_W-1:0] sin_coef;

  logic signed [PROD_W-1:0] p_cx;
  logic signed [PROD_W-1:0] p_sy;
  logic signed [PROD_W-1:0] p_sx;
  logic signed [PROD_W-1:0] p_cy;
  logic signed [ACC_W-1:0]  acc_x;
  logic signed [ACC_W-1:0]  acc_y;
  logic signed [ACC_W-1:0]  t_x;
  logic signed [ACC_W-1:0]  t_y;
  logic [XW-1:0]            x_raw;
  logic [XW-1:0]            y_raw;
  logic [DW-1:0]            w_use;
  logic [HW-1:0]            h_use;
  logic                     x_over;
  logic                     y_over;
  logic [CB-1:0]            x_idx;
  logic [RB-1:0]            y_idx;
  logic [CB-1:0]            x_idx_next;
  logic [RB-1:0]            y_idx_next;
  logic                     flag;
  logic signed [8:0]        col_s;
  logic signed [8:0]        row_s;
  logic [CB-1:0]            ld_col;
  logic [RB-1:0]            ld_row;
  logic [ADDR_W-1:0]        ram_addr;
  logic [PIX_W-1:0]         ram_rdata;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= IMAGE_WIDTH_RESET;
      image_height <= IMAGE_HEIGHT_RESET;
      cos_coef     <= COS_RESET;
      sin_coef     <= SIN_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_IMAGE_WIDTH:  image_width  <= cfg_data[DIM_W-1:0];
        CFG_IMAGE_HEIGHT: image_height <= cfg_data[DIM_W-1:0];
        CFG_COS_COEF:     cos_coef     <= signed'(cfg_data[COEF_W-1:0]);
        CFG_SIN_COEF:     sin_coef     <= signed'(cfg_data[COEF_W-1:0]);
        default: ;
      endcase
    end
  end

  assign w_use = DW'(sat_dim(image_width, MAX_WIDTH));
  assign h_use = HW'(sat_dim(image_height, MAX_HEIGHT));

  // products
  assign col_s = signed'({1'b0, col});
  assign row_s = signed'({1'b0, row});

  always_ff @(posedge clk) begin
    if (cmd.fetch_go) begin
      p_cx <= cos_coef * col_s;
      p_sy <= sin_coef * row_s;
      p_sx <= sin_coef * col_s;
      p_cy <= cos_coef * row_s;
    end
  end

  // sums
  always_ff @(posedge clk) begin
    if (cmd.sum_en) begin
      acc_x <= ACC_W'(p_cx) + ACC_W'(p_sy);
      acc_y <= ACC_W'(p_cy) - ACC_W'(p_sx);
    end
  end

  // round half up, drop negatives, clamp at the far edge
  assign t_x   = acc_x + HALF;
  assign t_y   = acc_y + HALF;
  assign x_raw = t_x[ACC_W-1] ? '0 : t_x[ACC_W-1:COEF_FRAC_BITS];
  assign y_raw = t_y[ACC_W-1] ? '0 : t_y[ACC_W-1:COEF_FRAC_BITS];

  assign x_over = (32'(x_raw) >= 32'(w_use));
  assign y_over = (32'(y_raw) >= 32'(h_use));

  assign x_idx_next = x_over ? CB'(w_use - DW'(1)) : CB'(x_raw);
  assign y_idx_next = y_over ? RB'(h_use - HW'(1)) : RB'(y_raw);

  always_ff @(posedge clk) begin
    if (cmd.rnd_en) begin
      x_idx <= x_idx_next;
      y_idx <= y_idx_next;
      flag  <= x_over | y_over;
    end
  end

  // frame store
  assign ld_col   = CB'(mod8(col, MAX_WIDTH));
  assign ld_row   = RB'(mod8(row, MAX_HEIGHT));
  assign ram_addr = cmd.load_we ? {ld_row, ld_col} : {y_idx, x_idx};

  irn_ram #(
    .WIDTH(PIX_W),
    .DEPTH(DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (cmd.load_we),
    .re   (cmd.rd_en),
    .addr (ram_addr),
    .wdata({chan2, chan1, chan0}),
    .rdata(ram_rdata)
  );

  assign out_chan0 = ram_rdata[7:0];
  assign out_chan1 = ram_rdata[15:8];
  assign out_chan2 = ram_rdata[23:16];
  assign src_col   = 8'(x_idx);
  assign src_row   = 8'(y_idx);
  assign clamped   = flag;

endmodule

FILE: tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for image_rotate_nearest_core. Load and fetch words are
// sent over the start/busy port with random gaps; a shadow frame store and a
// rotation predictor work out each fetch result, which a monitor checks on
// every done strobe. Each fetch whose source pixel has not been loaded yet is
// preceded by a load of that pixel. Register settings include the extremes
// and out-of-range values.
// ----------------------------------------------------------------------------
module tb;
  import irn_pkg::*;

  localparam int CYCLE_LIMIT  = 500000;
  localparam int DRAIN_CYCLES = 8;

  typedef struct packed {
    logic [7:0] c0;
    logic [7:0] c1;
    logic [7:0] c2;
    logic [7:0] sc;
    logic [7:0] sr;
    logic       clamped;
  } fetch_word_t;

  logic                   clk;
  logic                   rst;
  logic                   start;
  logic                   busy;
  logic                   op;
  logic [7:0]             col;
  logic [7:0]             row;
  logic [7:0]             chan0;
  logic [7:0]             chan1;
  logic [7:0]             chan2;
  logic                   done;
  logic [7:0]             out_chan0;
  logic [7:0]             out_chan1;
  logic [7:0]             out_chan2;
  logic [7:0]             src_col;
  logic [7:0]             src_row;
  logic                   clamped;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  // shadow of the block: frame store and registers
  logic [PIX_W-1:0]         frame_copy [0:65535];
  bit                       frame_written [0:65535];
  logic [DIM_W-1:0]         cur_width;
  logic [DIM_W-1:0]         cur_height;
  logic signed [COEF_W-1:0] cur_cos;
  logic signed [COEF_W-1:0] cur_sin;

  fetch_word_t pending_fetches[$];

  int unsigned cycle_count;
  int unsigned fault_count;
  int unsigned load_count;
  int unsigned fetch_count;
  int unsigned clamp_count;
  int unsigned setting_count;
  int unsigned quiet_left;
  bit          quiet_run;

  image_rotate_nearest_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .op        (op),
    .col       (col),
    .row       (row),
    .chan0     (chan0),
    .chan1     (chan1),
    .chan2     (chan2),
    .done      (done),
    .out_chan0 (out_chan0),
    .out_chan1 (out_chan1),
    .out_chan2 (out_chan2),
    .src_col   (src_col),
    .src_row   (src_row),
    .clamped   (clamped),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic flag_fault(input string msg);
    fault_count++;
    if (fault_count <= 10) begin
      $display("[%0t] %s", $time, msg);
    end
  endtask

  function automatic longint round_half_up(input longint acc);
    longint t;
    t = acc + (longint'(1) << (DEF_COEF_FRAC_BITS - 1));
    return (t < 0) ? longint'(0) : (t >>> DEF_COEF_FRAC_BITS);
  endfunction

  function automatic void map_source(input logic [7:0] cx, input logic [7:0] cy,
                                     output logic [7:0] sx, output logic [7:0] sy,
                                     output logic flag);
    longint w, h, x, y, px, py, cc, ss;
    px = cx;
    py = cy;
    cc = cur_cos;
    ss = cur_sin;
    w = (cur_width == 0) ? 1 : ((cur_width > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : cur_width);
    h = (cur_height == 0) ? 1 : ((cur_height > DEF_MAX_HEIGHT) ? DEF_MAX_HEIGHT : cur_height);
    x = round_half_up(cc * px + ss * py);
    y = round_half_up(-ss * px + cc * py);
    flag = 1'b0;
    if (x >= w) begin
      x = w - 1;
      flag = 1'b1;
    end
    if (y >= h) begin
      y = h - 1;
      flag = 1'b1;
    end
    sx = 8'(x);
    sy = 8'(y);
  endfunction

  // check each fetch result against the oldest prediction
  always @(posedge clk) begin
    fetch_word_t want;
    fetch_word_t got;
    if (!rst && done) begin
      got = '{out_chan0, out_chan1, out_chan2, src_col, src_row, clamped};
      if (pending_fetches.size() == 0) begin
        flag_fault($sformatf("unexpected result: ch %02h %02h %02h src (%0d,%0d) clamp %0d",
                             got.c0, got.c1, got.c2, got.sc, got.sr, got.clamped));
      end else begin
        want = pending_fetches.pop_front();
        if (got !== want) begin
          flag_fault($sformatf({"fetch mismatch: expected ch %02h %02h %02h src (%0d,%0d) ",
                                "clamp %0d, got ch %02h %02h %02h src (%0d,%0d) clamp %0d"},
                               want.c0, want.c1, want.c2, want.sc, want.sr, want.clamped,
                               got.c0, got.c1, got.c2, got.sc, got.sr, got.clamped));
        end
      end
    end
  end

  task automatic send_word(input logic kind, input logic [7:0] cx, input logic [7:0] cy,
                           input logic [7:0] p0, input logic [7:0] p1, input logic [7:0] p2);
    int unsigned gap;
    fetch_word_t want;
    logic [7:0]  sx;
    logic [7:0]  sy;
    logic        flag;
    if (quiet_left == 0) begin
      quiet_left = $urandom_range(8, 40);
      quiet_run  = ($urandom_range(0, 3) == 0);
    end
    quiet_left--;
    gap = quiet_run ? 0 : $urandom_range(0, 11);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    op    <= kind;
    col   <= cx;
    row   <= cy;
    chan0 <= p0;
    chan1 <= p1;
    chan2 <= p2;
    do @(posedge clk); while (busy);
    if (kind == OP_LOAD) begin
      frame_copy[{cy, cx}]    = {p2, p1, p0};
      frame_written[{cy, cx}] = 1'b1;
      load_count++;
    end else begin
      map_source(cx, cy, sx, sy, flag);
      want = '{frame_copy[{sy, sx}][7:0], frame_copy[{sy, sx}][15:8],
               frame_copy[{sy, sx}][23:16], sx, sy, flag};
      if (flag) clamp_count++;
      pending_fetches.push_back(want);
      fetch_count++;
    end
  endtask

  // load the source pixel first where it was never written
  task automatic fetch_at(input logic [7:0] cx, input logic [7:0] cy);
    logic [7:0] sx;
    logic [7:0] sy;
    logic       flag;
    map_source(cx, cy, sx, sy, flag);
    if (!frame_written[{sy, sx}]) begin
      send_word(OP_LOAD, sx, sy, 8'($urandom), 8'($urandom), 8'($urandom));
    end
    send_word(OP_FETCH, cx, cy, 8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  task automatic drain();
    start <= 1'b0;
    while (busy || pending_fetches.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_IMAGE_WIDTH:  cur_width  = value[DIM_W-1:0];
      CFG_IMAGE_HEIGHT: cur_height = value[DIM_W-1:0];
      CFG_COS_COEF:     cur_cos    = value;
      CFG_SIN_COEF:     cur_sin    = value;
      default: ;
    endcase
  endtask

  task automatic apply_setting(input logic [15:0] w, input logic [15:0] h,
                               input logic [15:0] c, input logic [15:0] s);
    drain();
    write_register(CFG_IMAGE_WIDTH, w);
    write_register(CFG_IMAGE_HEIGHT, h);
    write_register(CFG_COS_COEF, c);
    write_register(CFG_SIN_COEF, s);
    cfg_valid <= 1'b0;
    setting_count++;
  endtask

  // reset registers: corners, negative coordinates, upper clamp
  task automatic test_reset_setting();
    send_word(OP_LOAD, 8'd0, 8'd0, 8'h00, 8'h00, 8'h00);
    send_word(OP_LOAD, 8'd255, 8'd255, 8'hFF, 8'hFF, 8'hFF);
    send_word(OP_LOAD, 8'd255, 8'd0, 8'hAA, 8'h55, 8'hF0);
    fetch_at(8'd0, 8'd0);
    fetch_at(8'd255, 8'd255);
    fetch_at(8'd255, 8'd0);
    fetch_at(8'd0, 8'd255);
    fetch_at(8'd128, 8'd64);
  endtask

  // saturated dimensions and coefficients at and beyond unit magnitude
  task automatic test_register_extremes();
    apply_setting(16'hFE00, 16'h01FF, 16'h7FFF, 16'h8000);
    fetch_at(8'd255, 8'd255);
    fetch_at(8'd1, 8'd0);
    fetch_at(8'd0, 8'd1);
    apply_setting(16'd256, 16'd1, 16'hC000, 16'h4000);
    fetch_at(8'd0, 8'd0);
    fetch_at(8'd255, 8'd255);
    fetch_at(8'd17, 8'd200);
  endtask

  task automatic run_random_items(input int unsigned n_items);
    int unsigned    target;
    logic [7:0]     cx;
    logic [7:0]     cy;
    target = load_count + fetch_count + n_items;
    while (load_count + fetch_count < target) begin
      if ($urandom_range(0, 99) < 30) begin
        send_word(OP_LOAD, 8'($urandom), 8'($urandom),
                  8'($urandom), 8'($urandom), 8'($urandom));
      end else begin
        if ($urandom_range(0, 1) == 0) begin
          cx = 8'($urandom);
          cy = 8'($urandom);
        end else begin
          cx = 8'($urandom_range(0, 24));
          cy = 8'($urandom_range(0, 24));
        end
        fetch_at(cx, cy);
      end
    end
  endtask

  function automatic logic [15:0] pick_dim();
    return ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(1, 256));
  endfunction

  function automatic logic [15:0] pick_coef();
    return ($urandom_range(0, 5) == 0) ? 16'($urandom) : 16'(int'($urandom_range(0, 32768)) - 16384);
  endfunction

  task automatic test_random_settings();
    apply_setting(16'd256, 16'd256, 16'sd16384, 16'sd0);
    run_random_items(115);
    apply_setting(16'd1, 16'd1, -16'sd16384, 16'sd16384);
    run_random_items(115);
    apply_setting(16'd256, 16'd1, 16'sd0, -16'sd16384);
    run_random_items(115);
    apply_setting(16'd1, 16'd256, -16'sd16384, -16'sd16384);
    run_random_items(115);
    apply_setting(16'd0, 16'd300, 16'sd0, 16'sd16384);
    run_random_items(115);
    repeat (7) begin
      apply_setting(pick_dim(), pick_dim(), pick_coef(), pick_coef());
      run_random_items(115);
    end
  endtask

  initial begin
    rst        <= 1'b1;
    start      <= 1'b0;
    op         <= OP_LOAD;
    col        <= '0;
    row        <= '0;
    chan0      <= '0;
    chan1      <= '0;
    chan2      <= '0;
    cfg_valid  <= 1'b0;
    cfg_index  <= CFG_IMAGE_WIDTH;
    cfg_data   <= '0;
    cur_width  = IMAGE_WIDTH_RESET;
    cur_height = IMAGE_HEIGHT_RESET;
    cur_cos    = COS_RESET;
    cur_sin    = SIN_RESET;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_setting();
    test_register_extremes();
    test_random_settings();
    drain();

    $display("Covered %0d loads and %0d fetches (%0d clamped) over %0d register settings",
             load_count, fetch_count, clamp_count, setting_count);
    $display("%0d faults in %0d cycles", fault_count, cycle_count);
    if (fault_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

FILE: sim.f
sv/irn_pkg.sv
sv/irn_ram.sv
sv/irn_ctrl.sv
sv/irn_dpath.sv
sv/image_rotate_nearest_core.sv
tb/tb.sv
